@@ rtl/pse_pkg.sv @@
// shared types and constants for the postfix stack evaluator
package pse_pkg;

    localparam int DATA_W = 32;

    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_PAREN = 3'd3,
        ST_DIVZ  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALU,
        S_DIV,
        S_WB,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    cap;
        logic    push;
        t_status raise;
        logic    alu_ld;
        logic    div_go;
        logic    div_ld;
        logic    wb;
        logic    emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_op;
        logic is_paren;
        logic is_div;
        logic has_two;
        logic can_push;
        logic y_zero;
        logic last;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/pse_ram.sv @@
// generic simple dual-port ram with registered read
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pse_div.sv @@
// iterative restoring divider, signed 32-bit, truncates toward zero
module pse_div
    import pse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int CW = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W-1:0] w_mx;
    logic [DATA_W-1:0] w_my;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    assign w_mx    = i_x[DATA_W-1] ? (DATA_W'(0) - i_x) : i_x;
    assign w_my    = i_y[DATA_W-1] ? (DATA_W'(0) - i_y) : i_y;
    assign w_shift = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_x[DATA_W-1] ^ i_y[DATA_W-1];
            r_rem <= '0;
            r_quo <= w_mx;
            r_dvs <= w_my;
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

@@ rtl/pse_dp.sv @@
// datapath: item capture, operand stack, alu, divider and result register
module pse_dp
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [7:0]        i_symbol,
    input  logic              i_end_of_expr,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_value,
    output logic [2:0]        o_status
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]        r_sym;
    logic              r_last;
    logic [DW-1:0]     r_depth;
    t_status           r_status;
    logic [DATA_W-1:0] r_tos;
    logic [DATA_W-1:0] r_res;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_out_status;

    logic [DW-1:0]     w_below;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_digit;
    logic [DATA_W-1:0] w_x;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_quot;
    logic              w_div_done;

    assign w_below = r_depth - DW'(2);
    assign w_raddr = w_below[AW-1:0];
    assign w_digit = {{(DATA_W-8){1'b0}}, r_sym} - {{(DATA_W-8){1'b0}}, CH_ZERO};
    assign w_waddr = i_cmd.push ? r_depth[AW-1:0] : w_raddr;
    assign w_wdata = i_cmd.push ? w_digit : r_res;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push | i_cmd.wb),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_x)
    );

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_x     (w_x),
        .i_y     (r_tos),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // left operand from ram, right operand is the cached top
    always_comb begin
        case (r_sym)
            CH_ADD:  w_alu = w_x + r_tos;
            CH_SUB:  w_alu = w_x - r_tos;
            CH_MUL:  w_alu = w_x * r_tos;
            default: w_alu = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_sym  <= i_symbol;
            r_last <= i_end_of_expr;
        end
        if (i_cmd.push) begin
            r_tos <= w_digit;
        end else if (i_cmd.wb) begin
            r_tos <= r_res;
        end
        if (i_cmd.alu_ld) begin
            r_res <= w_alu;
        end else if (i_cmd.div_ld) begin
            r_res <= w_quot;
        end
        if (i_cmd.emit) begin
            r_out_value  <= (r_depth != '0) ? r_tos : '0;
            r_out_status <= (r_depth == '0 && r_status == ST_OK) ? ST_UNDER : r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_depth  <= '0;
                r_status <= ST_OK;
            end else begin
                if (i_cmd.push) begin
                    r_depth <= r_depth + DW'(1);
                end else if (i_cmd.wb) begin
                    r_depth <= r_depth - DW'(1);
                end
                if (i_cmd.raise != ST_OK && r_status == ST_OK) begin
                    r_status <= i_cmd.raise;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.is_op    = (r_sym == CH_ADD) || (r_sym == CH_SUB) ||
                          (r_sym == CH_MUL) || (r_sym == CH_DIV);
        o_stat.is_paren = (r_sym == CH_LPAREN) || (r_sym == CH_RPAREN);
        o_stat.is_div   = (r_sym == CH_DIV);
        o_stat.has_two  = (r_depth >= DW'(2));
        o_stat.can_push = (r_depth < DW'(STACK_DEPTH));
        o_stat.y_zero   = (r_tos == '0);
        o_stat.last     = r_last;
        o_stat.div_done = w_div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

endmodule

@@ rtl/pse_ctrl.sv @@
// controller state machine sequencing one item through the datapath
module pse_ctrl
    import pse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_op && !i_stat.is_paren && i_stat.has_two) n_state = S_ALU;
                else n_state = S_FIN;
            end
            S_ALU: begin
                if (i_stat.is_div && !i_stat.y_zero) n_state = S_DIV;
                else n_state = S_WB;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_WB;
            end
            S_WB: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.last || i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.raise = ST_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            S_DECODE: begin
                if (i_stat.is_paren) begin
                    o_cmd.raise = ST_PAREN;
                end else if (i_stat.is_op) begin
                    if (!i_stat.has_two) o_cmd.raise = ST_UNDER;
                end else if (i_stat.can_push) begin
                    o_cmd.push = 1'b1;
                end else begin
                    o_cmd.raise = ST_OVER;
                end
            end
            S_ALU: begin
                if (i_stat.is_div && !i_stat.y_zero) begin
                    o_cmd.div_go = 1'b1;
                end else begin
                    o_cmd.alu_ld = 1'b1;
                    if (i_stat.is_div) o_cmd.raise = ST_DIVZ;
                end
            end
            S_DIV: begin
                o_cmd.div_ld = i_stat.div_done;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
            end
            S_FIN: begin
                o_cmd.emit = i_stat.last && i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// top level of the postfix expression evaluator
//
// input channel: one character per item on i_symbol, with i_end_of_expr
// marking the final character; taken when i_in_valid and o_in_ready are high
// output channel: o_value and o_status, one item per expression, taken when
// o_out_valid and i_out_ready are high
// one item is worked on at a time: a digit or an error goes through decode
// and the final step, + - * also through the alu and write-back steps, and a
// division by nonzero also waits on the 32-step restoring divider; the result
// register is loaded in the final step, so o_out_valid rises together with
// o_in_ready
// the stack lives in a simple dual-port ram with the top entry cached in a
// register, so only the left operand needs a ram read
// reset (synchronous, active low) empties the stack, clears the sticky
// status and drops any pending result; the ram itself is not cleared
// a stalled receiver holds the result register; new items are still taken
// until a further result would need that register, and the block then
// waits in its final step until the pending item is taken
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_symbol,
    input  logic              i_end_of_expr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_value,
    output logic [2:0]        o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing of each item
    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stack, arithmetic and result holding
    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_symbol      (i_symbol),
        .i_end_of_expr (i_end_of_expr),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    // o_in_ready is never high straight after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready straight after an accepted item");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result register overwritten while pending");

    // the divider only finishes while an item is being worked on
    a_div_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> !o_in_ready)
        else $error("divider finished with no item in flight");

    // a stack write never coincides with accepting a new item
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.push || w_cmd.wb) |-> !o_in_ready)
        else $error("stack written while idle");

endmodule
